/* design/rtcb_pkg.sv */
// Shared constants, codes, request structs and BCD helper for the RTC register bridge.
`default_nettype none

package rtcb_pkg;

  localparam int MEM_BYTES  = 64;
  localparam int PTR_W      = $clog2(MEM_BYTES);
  localparam int TIME_REGS  = 7;
  localparam int BUSY_START = 2;

  typedef enum logic [2:0] {
    OP_WR_DATA   = 3'd0,
    OP_WR_CTRL   = 3'd1,
    OP_RD_DATA   = 3'd2,
    OP_RD_STATUS = 3'd3,
    OP_SOFT_RST  = 3'd4,
    OP_REFRESH   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2,
    PH_ERROR = 2'd3
  } phase_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

  typedef struct packed {
    logic       en;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] wday;
    logic [7:0] mday;
    logic [7:0] mon;
    logic [7:0] year;
  } refresh_req_t;

  // Tens found by independent compares against multiples of ten.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = '0;
    for (int k = 1; k <= 12; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    units = v - 7'(int'(tens) * 10);
    return {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

/* design/rtcb_ifs.sv */
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface rtcb_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] bus_value;
  logic [5:0] seconds;
  logic [5:0] minutes;
  logic [4:0] hours;
  logic [2:0] weekday;
  logic [4:0] day_of_month;
  logic [3:0] month_index;
  logic [6:0] year_in_century;

  modport source (
    output valid, operation, bus_value, seconds, minutes, hours, weekday,
           day_of_month, month_index, year_in_century,
    input  ready
  );
  modport sink (
    input  valid, operation, bus_value, seconds, minutes, hours, weekday,
           day_of_month, month_index, year_in_century,
    output ready
  );
endinterface

interface rtcb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

`default_nettype wire

/* design/rtcb_store.sv */
// Clock register file: time registers in flops, remaining bytes in a memory with valid bits.
`default_nettype none

module rtcb_store
  import rtcb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire wr_req_t          wr,
  input  wire refresh_req_t     rfs,
  input  wire logic [PTR_W-1:0] rd_addr,
  input  wire logic [PTR_W-1:0] rd_addr_next,
  output logic [7:0]            rd_byte
);

  logic [7:0]           time_reg [TIME_REGS];
  logic [7:0]           mem [MEM_BYTES];
  logic [MEM_BYTES-1:0] valid;
  logic [7:0]           rd_data;
  logic                 rd_valid;
  logic                 wr_time;

  assign wr_time = wr.addr < PTR_W'(TIME_REGS);

  // Time registers; refresh is skipped while the clock-halt bit is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIME_REGS; i++) time_reg[i] <= '0;
    end else if (rfs.en && !time_reg[0][7]) begin
      time_reg[0] <= rfs.sec;
      time_reg[1] <= rfs.min;
      time_reg[2] <= rfs.hr;
      time_reg[3] <= rfs.wday;
      time_reg[4] <= rfs.mday;
      time_reg[5] <= rfs.mon;
      time_reg[6] <= rfs.year;
    end else if (wr.en && wr_time) begin
      time_reg[wr.addr[2:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en && !wr_time) valid[wr.addr] <= 1'b1;
      rd_valid <= valid[rd_addr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr_time) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr_next];
  end

  always_comb begin
    if (rd_addr < PTR_W'(TIME_REGS)) rd_byte = time_reg[rd_addr[2:0]];
    else if (rd_valid)               rd_byte = rd_data;
    else                             rd_byte = '0;
  end

endmodule

`default_nettype wire

/* design/i2c_rtc_register_bridge_top.sv */
// Top level of the I2C RTC register bridge: host request decode, transfer control, response.
//
// Usage:
//   req carries one host register access per request (write data, write control,
//   read data, read status, soft reset, time refresh) plus the binary time fields
//   used by a refresh. rsp returns exactly one byte per request: the buffered read
//   byte, the status byte (bit0 busy, bit1 error), or zero.
// Latency: the response for a request is valid on the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; all work happens in a single
//   registered pass from the accepted request to the response register, with the
//   register file read ahead through a registered memory port at the next pointer value.
// Stall: req.ready drops only while the response register holds a byte that rsp
//   has not taken; a new request is accepted in the same cycle the old byte leaves.
// Reset: rst (synchronous, active high) clears all control state, the time
//   registers and the valid bits of the register memory, so every byte reads as
//   zero until written. No clearing pass is needed; requests are taken right away.
// Control writes are only armed; a status poll acts on them, and busy then counts
//   down over the following polls.
`default_nettype none

module i2c_rtc_register_bridge_top
  import rtcb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  rtcb_req_if.sink    req,
  rtcb_rsp_if.source  rsp
);

  logic             accept;
  op_t              op;

  logic [PTR_W-1:0] register_pointer, register_pointer_next;
  phase_t           transfer_phase, transfer_phase_next;
  logic [7:0]       outgoing_byte, outgoing_byte_next;
  logic [7:0]       incoming_byte, incoming_byte_next;
  logic [1:0]       busy_count, busy_count_next;
  logic             error_flag, error_flag_next;
  logic             control_pending, control_pending_next;
  logic [1:0]       control_bits, control_bits_next;
  logic [7:0]       previous_byte, previous_byte_next;
  logic             previous_direction, previous_direction_next;

  logic             out_valid;
  logic [7:0]       out_value;
  logic [7:0]       result;

  logic             handle;
  logic             ctrl_en;
  logic             ctrl_dir;
  phase_t           eff_phase;
  logic [PTR_W-1:0] ptr_inc;
  logic             addr_ok;
  logic [7:0]       rd_byte;
  logic [6:0]       year_mod;
  wr_req_t          wr;
  refresh_req_t     rfs;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;
  assign op        = op_t'(req.operation);

  // Control is acted on by a status poll once busy has expired.
  assign handle    = (op == OP_RD_STATUS) && (busy_count == '0) && control_pending;
  assign ctrl_en   = control_bits[0];
  assign ctrl_dir  = control_bits[1];
  // A repeat of the same byte and direction keeps the phase; anything else restarts.
  assign eff_phase = (incoming_byte == previous_byte && ctrl_dir == previous_direction)
                     ? transfer_phase : PH_IDLE;
  assign ptr_inc   = (register_pointer == PTR_W'(MEM_BYTES - 1))
                     ? '0 : register_pointer + PTR_W'(1);
  assign addr_ok   = {1'b0, incoming_byte} < 9'(MEM_BYTES);

  // Next-state logic for the transfer sequencer and its registers.
  always_comb begin
    register_pointer_next   = register_pointer;
    transfer_phase_next     = transfer_phase;
    outgoing_byte_next      = outgoing_byte;
    incoming_byte_next      = incoming_byte;
    busy_count_next         = busy_count;
    error_flag_next         = error_flag;
    control_pending_next    = control_pending;
    control_bits_next       = control_bits;
    previous_byte_next      = previous_byte;
    previous_direction_next = previous_direction;
    unique case (op)
      OP_WR_DATA: incoming_byte_next = req.bus_value;
      OP_WR_CTRL: begin
        control_bits_next    = req.bus_value[1:0];
        control_pending_next = 1'b1;
      end
      OP_RD_STATUS: begin
        if (busy_count != '0) begin
          busy_count_next = busy_count - 2'd1;
        end else if (!control_pending && transfer_phase == PH_READ) begin
          control_pending_next = 1'b1;
        end else if (handle) begin
          control_pending_next = 1'b0;
          if (!ctrl_en) begin
            transfer_phase_next = PH_IDLE;
            busy_count_next     = '0;
          end else begin
            busy_count_next         = 2'(BUSY_START);
            transfer_phase_next     = eff_phase;
            previous_byte_next      = incoming_byte;
            previous_direction_next = ctrl_dir;
            if (ctrl_dir) begin
              transfer_phase_next   = PH_READ;
              outgoing_byte_next    = rd_byte;
              register_pointer_next = ptr_inc;
              error_flag_next       = 1'b0;
            end else begin
              unique case (eff_phase)
                PH_IDLE: begin
                  if (addr_ok) begin
                    register_pointer_next = incoming_byte[PTR_W-1:0];
                    transfer_phase_next   = PH_WRITE;
                    error_flag_next       = 1'b0;
                  end else begin
                    error_flag_next     = 1'b1;
                    transfer_phase_next = PH_ERROR;
                  end
                end
                PH_WRITE: begin
                  register_pointer_next = ptr_inc;
                  error_flag_next       = 1'b0;
                end
                PH_READ: begin
                  error_flag_next     = 1'b1;
                  transfer_phase_next = PH_ERROR;
                end
                default: ;
              endcase
            end
          end
        end
      end
      OP_SOFT_RST: begin
        transfer_phase_next     = PH_IDLE;
        busy_count_next         = '0;
        error_flag_next         = 1'b0;
        control_pending_next    = 1'b0;
        previous_byte_next      = '0;
        previous_direction_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Outputs of the pass: response byte, memory write and time refresh requests.
  always_comb begin
    result = '0;
    unique case (op)
      OP_RD_DATA:   result = outgoing_byte;
      OP_RD_STATUS: result = {6'b0, error_flag, busy_count != '0};
      default: ;
    endcase
  end

  assign wr.en   = accept && handle && ctrl_en && !ctrl_dir && (eff_phase == PH_WRITE);
  assign wr.addr = register_pointer;
  assign wr.data = incoming_byte;

  assign year_mod = (req.year_in_century >= 7'd100)
                    ? req.year_in_century - 7'd100 : req.year_in_century;

  assign rfs.en   = accept && (op == OP_REFRESH);
  assign rfs.sec  = to_bcd(7'(req.seconds)) & 8'h7F;
  assign rfs.min  = to_bcd(7'(req.minutes)) & 8'h7F;
  assign rfs.hr   = to_bcd(7'(req.hours)) & 8'h3F;
  assign rfs.wday = (req.weekday == 3'd0) ? 8'd7 : 8'(req.weekday);
  assign rfs.mday = to_bcd(7'(req.day_of_month)) & 8'h3F;
  assign rfs.mon  = to_bcd(7'(req.month_index) + 7'd1) & 8'h1F;
  assign rfs.year = to_bcd(year_mod);

  // Read ahead at the pointer value the next cycle will hold.
  rtcb_store u_store (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .rfs          (rfs),
    .rd_addr      (register_pointer),
    .rd_addr_next (accept ? register_pointer_next : register_pointer),
    .rd_byte      (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      register_pointer   <= '0;
      transfer_phase     <= PH_IDLE;
      outgoing_byte      <= '0;
      incoming_byte      <= '0;
      busy_count         <= '0;
      error_flag         <= 1'b0;
      control_pending    <= 1'b0;
      control_bits       <= '0;
      previous_byte      <= '0;
      previous_direction <= 1'b0;
    end else if (accept) begin
      register_pointer   <= register_pointer_next;
      transfer_phase     <= transfer_phase_next;
      outgoing_byte      <= outgoing_byte_next;
      incoming_byte      <= incoming_byte_next;
      busy_count         <= busy_count_next;
      error_flag         <= error_flag_next;
      control_pending    <= control_pending_next;
      control_bits       <= control_bits_next;
      previous_byte      <= previous_byte_next;
      previous_direction <= previous_direction_next;
    end
  end

  // Response register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_value <= result;
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;

endmodule

`default_nettype wire

/* design/rtcb_checker.sv */
// Port-level checks for the RTC register bridge, bound to the top level.
`default_nettype none

module rtcb_checker
  import rtcb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [2:0] req_operation,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_read_value
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // A response waiting to be taken stays up.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // No request slips in while the response register is full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request accepted over a stalled response");

  // Every non-read request yields its response on the next cycle, and that byte is zero.
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_operation != OP_RD_DATA && req_operation != OP_RD_STATUS
    |=> rsp_valid && rsp_read_value == 8'd0)
    else $error("non-read request returned nonzero byte");

  // A status poll right after a soft reset shows neither busy nor error.
  a_clean_status: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_operation == OP_SOFT_RST ##1 req_acc && req_operation == OP_RD_STATUS
    |=> rsp_valid && rsp_read_value == 8'd0)
    else $error("status not clear after soft reset");

endmodule

bind i2c_rtc_register_bridge_top rtcb_checker u_rtcb_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_operation  (req.operation),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value)
);

`default_nettype wire

/* test/i2c_rtc_register_bridge_top_test.sv */
// Self-checking testbench for the I2C RTC register bridge: directed and random host requests.
module i2c_rtc_register_bridge_top_test;
  import rtcb_pkg::*;

  // Operation codes that the package leaves unnamed; the block must ignore them.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Control byte bits and status byte bits.
  localparam logic [1:0] CTRL_ENABLE = 2'b01;
  localparam logic [1:0] CTRL_READ   = 2'b10;
  localparam logic [7:0] STAT_BUSY   = 8'h01;
  localparam logic [7:0] STAT_ERROR  = 8'h02;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int HOLD_CYCLES     = 150;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int MAX_REPORTS     = 10;

  // One host request with every field at its port width.
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] bus_value;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [6:0] year_in_century;
  } host_req_t;

  logic clk;
  logic rst;

  rtcb_req_if req();
  rtcb_rsp_if rsp();

  i2c_rtc_register_bridge_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Free-running clock, period 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the bridge: register file, pointer, transfer phase and the
  // host-visible buffers. Updated once per accepted request, in accept order.
  // ---------------------------------------------------------------------------
  logic [7:0]       rtc_mem [MEM_BYTES];
  logic [PTR_W-1:0] rtc_ptr;
  phase_t           rtc_phase;
  logic [7:0]       out_byte;
  logic [7:0]       in_byte;
  logic [7:0]       last_byte;
  logic             last_dir;
  logic [1:0]       busy_left;
  logic [1:0]       ctrl_bits;
  logic             err_flag;
  logic             ctrl_armed;

  // Response bytes still owed by the block, oldest first.
  logic [7:0] expected_bytes [$];

  int unsigned mismatches;
  int unsigned responses_checked;
  int unsigned requests_sent;
  int unsigned useful_sent;
  int unsigned cycle_count;
  int unsigned mem_stores;
  int unsigned addr_errors;
  int unsigned op_count [8];

  // Idling switch shared by sender and receiver; cleared for stretches of
  // back-to-back traffic.
  logic        idle_enable;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests;

  function automatic logic [7:0] bcd_byte(int unsigned v);
    return {4'((v / 10) % 16), 4'(v % 10)};
  endfunction

  function automatic logic [PTR_W-1:0] ptr_after(logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % MEM_BYTES);
  endfunction

  function automatic void clear_shadow();
    foreach (rtc_mem[i]) rtc_mem[i] = '0;
    rtc_ptr    = '0;
    rtc_phase  = PH_IDLE;
    out_byte   = '0;
    in_byte    = '0;
    last_byte  = '0;
    last_dir   = 1'b0;
    busy_left  = '0;
    ctrl_bits  = '0;
    err_flag   = 1'b0;
    ctrl_armed = 1'b0;
  endfunction

  // Move one byte: a read always fetches at the pointer; a write either sets
  // the pointer (fresh transfer), stores (write phase) or flags an error.
  function automatic void run_byte_transfer(logic is_read);
    if (is_read) begin
      rtc_phase = PH_READ;
      out_byte  = rtc_mem[rtc_ptr];
      rtc_ptr   = ptr_after(rtc_ptr);
      err_flag  = 1'b0;
      return;
    end
    case (rtc_phase)
      PH_IDLE: begin
        if (in_byte < MEM_BYTES) begin
          rtc_ptr   = in_byte[PTR_W-1:0];
          rtc_phase = PH_WRITE;
          err_flag  = 1'b0;
        end else begin
          err_flag  = 1'b1;
          rtc_phase = PH_ERROR;
          addr_errors++;
        end
      end
      PH_WRITE: begin
        rtc_mem[rtc_ptr] = in_byte;
        rtc_ptr  = ptr_after(rtc_ptr);
        err_flag = 1'b0;
        mem_stores++;
      end
      PH_READ: begin
        err_flag  = 1'b1;
        rtc_phase = PH_ERROR;
      end
      default: ;
    endcase
  endfunction

  function automatic void act_on_control();
    logic en;
    logic dir;
    en  = ctrl_bits[0];
    dir = ctrl_bits[1];
    ctrl_armed = 1'b0;
    if (!en) begin
      rtc_phase = PH_IDLE;
      busy_left = '0;
      return;
    end
    busy_left = 2'(BUSY_START);
    // Only an exact repeat of byte and direction keeps the current phase.
    if (!(in_byte == last_byte && dir == last_dir)) rtc_phase = PH_IDLE;
    run_byte_transfer(dir);
    last_byte = in_byte;
    last_dir  = dir;
  endfunction

  function automatic logic [7:0] status_poll();
    logic [7:0] stat;
    stat = '0;
    if (busy_left != 0) stat |= STAT_BUSY;
    if (err_flag) stat |= STAT_ERROR;
    if (busy_left != 0) busy_left--;
    else if (!ctrl_armed && rtc_phase == PH_READ) ctrl_armed = 1'b1;
    else if (ctrl_armed) act_on_control();
    return stat;
  endfunction

  function automatic void load_time(host_req_t r);
    // Bit 7 of register 0 halts the clock and blocks the refresh.
    if (rtc_mem[0][7]) return;
    rtc_mem[0] = bcd_byte(r.seconds) & 8'h7F;
    rtc_mem[1] = bcd_byte(r.minutes) & 8'h7F;
    rtc_mem[2] = bcd_byte(r.hours) & 8'h3F;
    rtc_mem[3] = (r.weekday == 3'd0) ? 8'd7 : 8'(r.weekday);
    rtc_mem[4] = bcd_byte(r.day_of_month) & 8'h3F;
    rtc_mem[5] = bcd_byte(r.month_index + 1) & 8'h1F;
    rtc_mem[6] = bcd_byte(r.year_in_century % 100);
  endfunction

  // Apply one request to the shadow and return the byte the block must answer.
  function automatic logic [7:0] rtc_predict(host_req_t r);
    logic [7:0] rv;
    rv = '0;
    op_count[r.operation]++;
    case (r.operation)
      OP_WR_DATA: in_byte = r.bus_value;
      OP_WR_CTRL: begin
        ctrl_bits  = r.bus_value[1:0];
        ctrl_armed = 1'b1;
      end
      OP_RD_DATA:   rv = out_byte;
      OP_RD_STATUS: rv = status_poll();
      OP_SOFT_RST: begin
        rtc_phase  = PH_IDLE;
        busy_left  = '0;
        err_flag   = 1'b0;
        ctrl_armed = 1'b0;
        last_byte  = '0;
        last_dir   = 1'b0;
      end
      OP_REFRESH: load_time(r);
      default: ;
    endcase
    return rv;
  endfunction

  // ---------------------------------------------------------------------------
  // Request helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones; none while idling is off.
  function automatic int idle_gap();
    int unsigned r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Fill every field across its full width, so every bit toggles.
  function automatic host_req_t random_request();
    host_req_t r;
    r.operation       = 3'($urandom);
    r.bus_value       = 8'($urandom);
    r.seconds         = 6'($urandom);
    r.minutes         = 6'($urandom);
    r.hours           = 5'($urandom);
    r.weekday         = 3'($urandom);
    r.day_of_month    = 5'($urandom);
    r.month_index     = 4'($urandom);
    r.year_in_century = 7'($urandom);
    return r;
  endfunction

  function automatic host_req_t make_request(logic [2:0] op, logic [7:0] bus);
    host_req_t r;
    r = random_request();
    r.operation = op;
    r.bus_value = bus;
    return r;
  endfunction

  // Calendar-legal time most of the time, raw field widths otherwise.
  function automatic host_req_t make_refresh(bit legal);
    host_req_t r;
    r = make_request(OP_REFRESH, 8'($urandom));
    if (legal) begin
      r.seconds         = 6'($urandom_range(0, 60));
      r.minutes         = 6'($urandom_range(0, 59));
      r.hours           = 5'($urandom_range(0, 23));
      r.weekday         = 3'($urandom_range(0, 6));
      r.day_of_month    = 5'($urandom_range(1, 31));
      r.month_index     = 4'($urandom_range(0, 11));
      r.year_in_century = 7'($urandom_range(0, 99));
    end
    return r;
  endfunction

  // Favor the time registers, then any address in the file, then illegal addresses.
  function automatic logic [7:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(0, TIME_REGS - 1));
    if (r < 85) return 8'($urandom_range(0, MEM_BYTES - 1));
    return 8'($urandom_range(MEM_BYTES, 255));
  endfunction

  // Offer one request, hold it until accepted, then record the byte it owes.
  // Called and returning on a rising edge; valid stays high when no gap follows.
  task automatic send_request(input host_req_t r);
    int gap;
    req.valid           <= 1'b1;
    req.operation       <= r.operation;
    req.bus_value       <= r.bus_value;
    req.seconds         <= r.seconds;
    req.minutes         <= r.minutes;
    req.hours           <= r.hours;
    req.weekday         <= r.weekday;
    req.day_of_month    <= r.day_of_month;
    req.month_index     <= r.month_index;
    req.year_in_century <= r.year_in_century;
    do @(posedge clk); while (!req.ready);
    expected_bytes.push_back(rtc_predict(r));
    requests_sent++;
    if (r.operation <= OP_REFRESH) useful_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] bus);
    send_request(make_request(op, bus));
  endtask

  task automatic send_polls(input int n);
    repeat (n) send_op(OP_RD_STATUS, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Poll and read straight out of reset: everything reads zero.
  task automatic test_reset_state();
    send_op(OP_RD_STATUS, 8'hFF);
    send_op(OP_RD_DATA, 8'h00);
  endtask

  // Address byte beyond the register file raises the error bit; soft reset clears it.
  task automatic test_address_error();
    send_op(OP_WR_DATA, 8'hFF);
    send_op(OP_WR_CTRL, {6'h3F, CTRL_ENABLE});
    send_polls(2);
    send_op(OP_SOFT_RST, 8'hA5);
    send_polls(1);
  endtask

  // Point at the last register, repeat the byte to store it, and wrap the pointer.
  task automatic test_write_wrap();
    send_op(OP_WR_DATA, 8'(MEM_BYTES - 1));
    send_op(OP_WR_CTRL, {6'h00, CTRL_ENABLE});
    send_polls(3);
    send_op(OP_WR_CTRL, {6'h00, CTRL_ENABLE});
    send_polls(1);
  endtask

  // Disabled control idles the transfer; a read then re-arms itself once busy ends.
  task automatic test_disable_and_read();
    send_op(OP_WR_CTRL, {6'h3F, CTRL_READ});
    send_polls(1);
    send_op(OP_WR_CTRL, {6'h00, CTRL_READ | CTRL_ENABLE});
    send_polls(4);
    send_op(OP_RD_DATA, 8'hFF);
  endtask

  // Refresh with every time field at all ones, then at zero (Sunday, day zero).
  task automatic test_time_refresh();
    host_req_t r;
    r = '1;
    r.operation = OP_REFRESH;
    send_request(r);
    r = '0;
    r.operation = OP_REFRESH;
    send_request(r);
  endtask

  // Spare operation codes change nothing and answer zero.
  task automatic test_spare_codes();
    send_op(OP_SPARE_6, 8'hFF);
    send_op(OP_SPARE_7, 8'hFF);
  endtask

  // Hold the response side off for a long stretch while requests keep coming,
  // so the response register fills and the block drops req.ready.
  task automatic test_backpressure();
    idle_enable   <= 1'b0;
    hold_requests <= hold_requests + 1;
    send_op(OP_WR_DATA, 8'h05);
    send_op(OP_WR_CTRL, {6'h00, CTRL_ENABLE});
    send_polls(6);
    send_op(OP_WR_CTRL, {6'h00, CTRL_READ | CTRL_ENABLE});
    send_polls(8);
    idle_enable <= 1'b1;
    repeat (4) send_op(OP_RD_DATA, 8'($urandom));
  endtask

  // Mostly well-formed transfers with random content, plus broken ones and noise.
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  addr;
    goal = useful_sent + RANDOM_REQUESTS;
    while (useful_sent < goal) begin
      // Flip idling now and then to get stretches of back-to-back traffic.
      if ($urandom_range(0, 99) < 8) idle_enable <= ~idle_enable;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Write burst: address byte, then repeated controls store that byte.
        addr = pick_address();
        send_op(OP_WR_DATA, addr);
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_op(OP_WR_CTRL, {6'($urandom), CTRL_ENABLE});
          send_polls($urandom_range(1, 5));
        end
      end else if (pick < 55) begin
        // Read burst, optionally after setting the pointer.
        if ($urandom_range(0, 1) != 0) begin
          addr = pick_address();
          send_op(OP_WR_DATA, addr);
          send_op(OP_WR_CTRL, {6'($urandom), CTRL_ENABLE});
          send_polls(3);
        end
        send_op(OP_WR_CTRL, {6'($urandom), CTRL_READ | CTRL_ENABLE});
        n = $urandom_range(3, 16);
        repeat (n) begin
          if ($urandom_range(0, 9) < 7) send_polls(1);
          else send_op(OP_RD_DATA, 8'($urandom));
        end
      end else if (pick < 65) begin
        send_request(make_refresh($urandom_range(0, 9) != 0));
      end else if (pick < 72) begin
        send_op(OP_WR_CTRL, {6'($urandom), 1'($urandom), 1'b0});
        send_polls($urandom_range(1, 3));
      end else if (pick < 76) begin
        send_op(OP_SOFT_RST, 8'($urandom));
        send_polls($urandom_range(0, 2));
      end else if (pick < 84) begin
        // Raw data and control bytes with any bit pattern.
        send_op(OP_WR_DATA, 8'($urandom));
        send_op(OP_WR_CTRL, 8'($urandom));
        send_polls($urandom_range(1, 4));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(random_request());
      end
    end
    idle_enable <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready with random stalls, plus long holds on request.
  // ---------------------------------------------------------------------------
  int unsigned hold_taken;
  int          hold_left;
  int          stall_left;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b0;
      hold_taken = hold_requests;
      hold_left  = 0;
      stall_left = 0;
    end else if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HOLD_CYCLES;
      rsp.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready  <= 1'b1;
      stall_left = idle_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Response checker: every taken byte must match the oldest one owed.
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0d at cycle %0d: %s, expected %02h, got %02h",
               mismatches, cycle_count, what, want, got);
  endfunction

  always @(posedge clk) begin : check_responses
    logic [7:0] want;
    if (!rst && rsp.valid && rsp.ready) begin
      responses_checked++;
      if (expected_bytes.size() == 0) begin
        flag_mismatch("response with no request outstanding", 'x, rsp.read_value);
      end else begin
        want = expected_bytes.pop_front();
        if (rsp.read_value !== want) flag_mismatch("read_value", want, rsp.read_value);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_bytes.size());
      $display("i2c_rtc_register_bridge_top_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tests, back-pressure, random traffic, drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    req.valid           <= 1'b0;
    req.operation       <= '0;
    req.bus_value       <= '0;
    req.seconds         <= '0;
    req.minutes         <= '0;
    req.hours           <= '0;
    req.weekday         <= '0;
    req.day_of_month    <= '0;
    req.month_index     <= '0;
    req.year_in_century <= '0;
    idle_enable         <= 1'b1;
    hold_requests       <= 0;
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_address_error();
    test_write_wrap();
    test_disable_and_read();
    test_time_refresh();
    test_spare_codes();
    test_backpressure();
    test_random_traffic();

    // Drop valid, wait for every owed byte, then let the pipe settle.
    req.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d status polls, %0d data reads, %0d time refreshes",
             requests_sent, op_count[OP_RD_STATUS], op_count[OP_RD_DATA],
             op_count[OP_REFRESH]);
    $display("%0d responses checked, %0d register stores, %0d address errors, %0d mismatches",
             responses_checked, mem_stores, addr_errors, mismatches);
    if (mismatches == 0) begin
      $display("i2c_rtc_register_bridge_top_test: done, clean");
    end else begin
      $display("i2c_rtc_register_bridge_top_test: done, errors");
    end
    $finish;
  end

endmodule
